@@ sv/mwto_pkg.sv @@
package mwto_pkg;

	localparam int unsigned DEF_FRAME_SIZE     = 256;
	localparam int unsigned DEF_MIN_FRAME_SIZE = 64;
	localparam int unsigned DEF_MIP_LEVELS     = 4;
	localparam int unsigned DEF_MAX_HARMONICS  = 128;
	localparam int unsigned DEF_MAX_FRAMES     = 16;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MORPH_POS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_CNT = 2'd2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef struct packed {
		logic               command;
		logic [1:0]         write_level;
		logic [3:0]         write_frame;
		logic [7:0]         write_index;
		logic signed [15:0] write_value;
	} item_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic [1:0]         level_used;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADDR,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_MIX_HI,
		ST_OUT,
		ST_OUT_ZERO
	} state_t;

	typedef struct packed {
		logic       wr_en;
		logic       start;
		logic       mul;
		logic       addr;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       hold_a;
		logic       mix_lo;
		logic       mix_hi;
		logic       load_out;
		logic       zero_out;
	} cmd_t;

	typedef struct packed {
		logic tick;
		logic silent;
		logic out_free;
	} stat_t;

endpackage

@@ sv/mwto_ctrl.sv @@
module mwto_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  mwto_pkg::stat_t stat,
	output mwto_pkg::cmd_t  cmd
);
	import mwto_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (stat.tick) begin
						cmd.start = 1'b1;
						state_d   = stat.silent ? ST_OUT_ZERO : ST_MUL;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADDR;
			end
			ST_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = ST_RD0;
			end
			ST_RD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = 2'd0;
				state_d    = ST_RD1;
			end
			// read data is registered and arrives in the cycle after its address
			ST_RD1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = 2'd1;
				cmd.hold_a = 1'b1;
				state_d    = ST_RD2;
			end
			ST_RD2: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = 2'd2;
				cmd.mix_lo = 1'b1;
				state_d    = ST_RD3;
			end
			ST_RD3: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = 2'd3;
				cmd.hold_a = 1'b1;
				state_d    = ST_MIX_HI;
			end
			ST_MIX_HI: begin
				cmd.mix_hi = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_OUT_ZERO: begin
				if (stat.out_free) begin
					cmd.zero_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/mwto_datapath.sv @@
module mwto_datapath #(
	parameter int unsigned FRAME_SIZE     = mwto_pkg::DEF_FRAME_SIZE,
	parameter int unsigned MIN_FRAME_SIZE = mwto_pkg::DEF_MIN_FRAME_SIZE,
	parameter int unsigned MIP_LEVELS     = mwto_pkg::DEF_MIP_LEVELS,
	parameter int unsigned MAX_HARMONICS  = mwto_pkg::DEF_MAX_HARMONICS,
	parameter int unsigned MAX_FRAMES     = mwto_pkg::DEF_MAX_FRAMES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mwto_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mwto_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  mwto_pkg::item_t                     item,
	output mwto_pkg::result_t                   result,
	output logic                                result_valid,
	input  logic                                result_ready,
	input  mwto_pkg::cmd_t                      cmd,
	output mwto_pkg::stat_t                     stat
);
	import mwto_pkg::*;

	localparam int unsigned SLOT  = (FRAME_SIZE > MIN_FRAME_SIZE) ? FRAME_SIZE : MIN_FRAME_SIZE;
	localparam int unsigned DEPTH = MIP_LEVELS * MAX_FRAMES * SLOT;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned IW    = $clog2(SLOT);
	localparam int unsigned SW    = $clog2(SLOT + 1);
	localparam int unsigned LW    = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1;
	localparam int unsigned FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int unsigned FCW   = $clog2(MAX_FRAMES + 1);
	localparam int unsigned XW    = 32 + SW;
	localparam int unsigned PW    = 17 + FCW;
	localparam logic [16:0] POS_ONE = 17'h10000;

	// per-level frame size and increment threshold for the harmonic limit
	logic [SW-1:0] size_tab [MIP_LEVELS];
	logic [31:0]   thr_tab  [MIP_LEVELS];

	for (genvar m = 0; m < MIP_LEVELS; m++) begin : g_lvl
		localparam int unsigned SZ_RAW = FRAME_SIZE >> m;
		localparam int unsigned SZ     = (SZ_RAW > MIN_FRAME_SIZE) ? SZ_RAW : MIN_FRAME_SIZE;
		localparam int unsigned HM_RAW = MAX_HARMONICS >> m;
		localparam int unsigned HM     = (HM_RAW > 1) ? HM_RAW : 1;
		localparam longint unsigned THR = 64'h8000_0000 / HM;
		assign size_tab[m] = SW'(SZ);
		assign thr_tab[m]  = 32'(THR);
	end

	// configuration and phase
	logic [31:0] inc_q;
	logic [16:0] pos_q;
	logic [4:0]  fcount_q;
	logic [31:0] phase_q;
	logic        result_valid_q;

	// per-tick working registers
	logic [LW-1:0]      level_q;
	logic [FCW-1:0]     frames_q;
	logic [XW-1:0]      x_q;
	logic [PW-1:0]      p_q;
	logic [15:0]        frac_q;
	logic [15:0]        ffrac_q;
	logic [IW-1:0]      a0_q, a1_q;
	logic [AW-1:0]      row0_q, row1_q;
	logic signed [15:0] rd_q, hold_q, lower_q, upper_q;
	result_t            result_q;
	logic signed [15:0] table_q [DEPTH];

	// level choice: first level whose harmonics fit within half the rate, else the last
	logic [LW-1:0] level_d;
	always_comb begin
		level_d = LW'(MIP_LEVELS - 1);
		for (int m = int'(MIP_LEVELS) - 2; m >= 0; m--) begin
			if (inc_q <= thr_tab[m]) level_d = LW'(m);
		end
	end

	logic [FCW-1:0] frames_d;
	assign frames_d = (32'(fcount_q) > MAX_FRAMES) ? FCW'(MAX_FRAMES) : FCW'(fcount_q);

	logic [16:0] pos_c;
	assign pos_c = (pos_q > POS_ONE) ? POS_ONE : pos_q;

	// address split
	logic [IW-1:0] i0;
	logic [IW:0]   i0_inc;
	logic [IW-1:0] a1_d;
	logic [FW-1:0] f0, f1;
	logic [31:0]   row0_d, row1_d;
	always_comb begin
		i0     = x_q[32 +: IW];
		i0_inc = {1'b0, i0} + 1'b1;
		a1_d   = (i0_inc >= (IW+1)'(size_tab[level_q])) ? '0 : IW'(i0_inc);
		f0     = p_q[16 +: FW];
		f1     = ((32'(f0) + 32'd1) < 32'(frames_q)) ? FW'(32'(f0) + 32'd1)
			: FW'(32'(frames_q) - 32'd1);
		row0_d = (32'(level_q) * MAX_FRAMES + 32'(f0)) * SLOT;
		row1_d = (32'(level_q) * MAX_FRAMES + 32'(f1)) * SLOT;
	end

	// write address and range check
	logic [SW-1:0] wsize;
	logic          wr_ok;
	logic [31:0]   waddr;
	always_comb begin
		wsize = '0;
		for (int m = 0; m < int'(MIP_LEVELS); m++) begin
			if (32'(item.write_level) == 32'(m)) wsize = size_tab[m];
		end
		wr_ok = (32'(item.write_level) < MIP_LEVELS) && (32'(item.write_frame) < MAX_FRAMES)
			&& (32'(item.write_index) < 32'(wsize));
		waddr = (32'(item.write_level) * MAX_FRAMES + 32'(item.write_frame)) * SLOT
			+ 32'(item.write_index);
	end

	logic [AW-1:0] raddr, mem_addr;
	assign raddr    = (cmd.rd_sel[1] ? row1_q : row0_q) + AW'(cmd.rd_sel[0] ? a1_q : a0_q);
	assign mem_addr = cmd.wr_en ? AW'(waddr) : raddr;

	// shared blend unit: a + floor((b - a) * frac / 65536)
	logic signed [15:0] bl_a, bl_b;
	logic [15:0]        bl_f;
	logic signed [16:0] bl_d;
	logic signed [33:0] bl_p;
	logic [17:0]        bl_s;
	always_comb begin
		if (cmd.load_out) begin
			bl_a = lower_q;
			bl_b = upper_q;
			bl_f = ffrac_q;
		end else begin
			bl_a = hold_q;
			bl_b = rd_q;
			bl_f = frac_q;
		end
		bl_d = 17'(bl_b) - 17'(bl_a);
		bl_p = bl_d * $signed({1'b0, bl_f});
		bl_s = 18'(bl_a) + bl_p[33:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q          <= '0;
			pos_q          <= '0;
			fcount_q       <= '0;
			phase_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PHASE_INC: inc_q    <= cfg_data;
					CFG_MORPH_POS: pos_q    <= cfg_data[16:0];
					CFG_FRAME_CNT: fcount_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (cmd.load_out) phase_q <= phase_q + inc_q;
			if (cmd.load_out || cmd.zero_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			level_q  <= level_d;
			frames_q <= frames_d;
		end
		if (cmd.mul) begin
			x_q <= XW'(phase_q) * XW'(size_tab[level_q]);
			p_q <= PW'(pos_c) * PW'(frames_q - 1'b1);
		end
		if (cmd.addr) begin
			a0_q    <= i0;
			a1_q    <= a1_d;
			frac_q  <= x_q[31:16];
			ffrac_q <= p_q[15:0];
			row0_q  <= AW'(row0_d);
			row1_q  <= AW'(row1_d);
		end
		if (cmd.hold_a) hold_q  <= rd_q;
		if (cmd.mix_lo) lower_q <= bl_s[15:0];
		if (cmd.mix_hi) upper_q <= bl_s[15:0];
		if (cmd.load_out) begin
			result_q.sample_out <= bl_s[15:0];
			result_q.level_used <= 2'(level_q);
		end else if (cmd.zero_out) begin
			result_q.sample_out <= '0;
			result_q.level_used <= 2'(level_q);
		end
	end

	// single-port table store
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			if (wr_ok) table_q[mem_addr] <= item.write_value;
		end else if (cmd.rd_en) begin
			rd_q <= table_q[mem_addr];
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;
	assign stat.tick     = (item.command == CMD_TICK);
	assign stat.silent   = (fcount_q == '0);
	assign stat.out_free = !result_valid_q || result_ready;

endmodule

@@ sv/mipmapped_wavetable_oscillator_top.sv @@
// Wavetable oscillator with a band-limited level pyramid and frame morphing.
// item channel (item_valid/item_ready/item): taken only while idle. A write
// word stores one table sample if its address is in range; a tick word gives
// one result word and advances the phase accumulator unless the frame count is zero.
// result channel (result_valid/result_ready/result): one word per tick,
// held in an output register until taken.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is always
// high; index 0 is the phase increment, 1 the morph position, 2 the frame
// count. Write these only while the block is idle.
// A tick steps through the multiply and address stages, the four reads from the
// single-port table and the blend stages before it loads its result; a tick
// with a zero frame count skips them and loads a zero result. A new word is
// taken only once the previous tick has loaded its result.
// A stalled receiver holds the result register; the next tick then waits in
// its last step until that register frees up.
// Reset clears the configuration, the phase and the result valid; the table is
// not cleared, and every entry must be written before it is read.
module mipmapped_wavetable_oscillator_top #(
	parameter int unsigned FRAME_SIZE     = mwto_pkg::DEF_FRAME_SIZE,
	parameter int unsigned MIN_FRAME_SIZE = mwto_pkg::DEF_MIN_FRAME_SIZE,
	parameter int unsigned MIP_LEVELS     = mwto_pkg::DEF_MIP_LEVELS,
	parameter int unsigned MAX_HARMONICS  = mwto_pkg::DEF_MAX_HARMONICS,
	parameter int unsigned MAX_FRAMES     = mwto_pkg::DEF_MAX_FRAMES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mwto_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mwto_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  mwto_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output mwto_pkg::result_t               result
);
	import mwto_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	mwto_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	mwto_datapath #(
		.FRAME_SIZE     (FRAME_SIZE),
		.MIN_FRAME_SIZE (MIN_FRAME_SIZE),
		.MIP_LEVELS     (MIP_LEVELS),
		.MAX_HARMONICS  (MAX_HARMONICS),
		.MAX_FRAMES     (MAX_FRAMES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.stat         (stat)
	);

	// table port is shared between writes and reads
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.rd_en))
		else $error("table written and read in the same cycle");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_en || cmd.mix_hi || cmd.addr || cmd.mul) |-> !item_ready)
		else $error("input taken while a tick is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out || cmd.zero_out) |-> (!result_valid || result_ready))
		else $error("result register overwritten before it was taken");

	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.zero_out |=> (result_valid && result.sample_out == 16'sd0))
		else $error("silent tick gave a nonzero sample");

endmodule

@@ sim/mipmapped_wavetable_oscillator_top_tb.sv @@
module mipmapped_wavetable_oscillator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mwto_pkg::*;

	localparam int SETTLE      = 12;
	localparam int HOLD_CYCLES = 200;
	localparam int RAND_WORDS  = 300;

	typedef enum logic {STEP_CFG, STEP_WORD} step_kind_t;

	typedef struct {
		step_kind_t             kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		item_t                  word;
		bit                     typed;
		result_t                want;
	} step_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	item_t                 item = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;

	// predicted block state
	logic [31:0]        inc_reg = '0;
	logic [16:0]        morph_reg = '0;
	logic [4:0]         fcnt_reg = '0;
	logic [31:0]        phase_acc = '0;
	logic signed [15:0] wave_mem [0:16383];

	result_t due_samples [$];
	result_t head;
	int      err_cnt = 0;
	bit      steady = 1'b0;
	bit      hold_go = 1'b0;
	bit      hold_done = 1'b0;

	mipmapped_wavetable_oscillator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int unsigned lvl_size(int unsigned m);
		int unsigned s;
		s = DEF_FRAME_SIZE >> m;
		return (s > DEF_MIN_FRAME_SIZE) ? s : DEF_MIN_FRAME_SIZE;
	endfunction

	function automatic int unsigned lvl_harm(int unsigned m);
		int unsigned h;
		h = DEF_MAX_HARMONICS >> m;
		return (h > 1) ? h : 1;
	endfunction

	// a + floor((b - a) * frac / 2^16)
	function automatic int mix16(int a, int b, int unsigned frac);
		longint prod;
		prod = longint'(b - a) * longint'(frac);
		return a + int'(prod >>> 16);
	endfunction

	function automatic bit osc_advance(input item_t it, output result_t r);
		int unsigned       lvl, sz, nfr, pos, i0, i1, frac, f0, f1, ffrac;
		longint unsigned   x, p;
		int                lo, hi, mixed;
		r = '0;
		if (it.command == CMD_WRITE) begin
			if (it.write_index < lvl_size(it.write_level))
				wave_mem[{it.write_level, it.write_frame, it.write_index}] = it.write_value;
			return 1'b0;
		end
		lvl = 0;
		while (lvl + 1 < DEF_MIP_LEVELS &&
		       64'(lvl_harm(lvl)) * 64'(inc_reg) > 64'h8000_0000)
			lvl++;
		r.level_used = lvl[1:0];
		nfr = (fcnt_reg > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : fcnt_reg;
		if (nfr == 0)
			return 1'b1;
		sz = lvl_size(lvl);
		x = 64'(phase_acc) * 64'(sz);
		i0 = x[63:32];
		frac = x[31:16];
		i1 = (i0 + 1 >= sz) ? 0 : i0 + 1;
		pos = (morph_reg > 65536) ? 65536 : morph_reg;
		p = 64'(pos) * 64'(nfr - 1);
		f0 = p[47:16];
		ffrac = p[15:0];
		f1 = (f0 + 1 < nfr) ? f0 + 1 : nfr - 1;
		lo = mix16(wave_mem[{lvl[1:0], f0[3:0], i0[7:0]}],
		           wave_mem[{lvl[1:0], f0[3:0], i1[7:0]}], frac);
		hi = mix16(wave_mem[{lvl[1:0], f1[3:0], i0[7:0]}],
		           wave_mem[{lvl[1:0], f1[3:0], i1[7:0]}], frac);
		mixed = mix16(lo, hi, ffrac);
		r.sample_out = mixed[15:0];
		phase_acc = phase_acc + inc_reg;
		return 1'b1;
	endfunction

	function automatic item_t mk_word(logic cmd, int unsigned lvl, int unsigned frm,
	                                  int unsigned idx, int val);
		item_t it;
		it.command = cmd;
		it.write_level = lvl[1:0];
		it.write_frame = frm[3:0];
		it.write_index = idx[7:0];
		it.write_value = val[15:0];
		return it;
	endfunction

	function automatic step_t at_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		step_t s;
		s.kind = STEP_CFG;
		s.idx = idx;
		s.data = data;
		s.word = '0;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic step_t at_word(item_t it, bit typed, int smp, int lvl);
		step_t s;
		s.kind = STEP_WORD;
		s.idx = '0;
		s.data = '0;
		s.word = it;
		s.typed = typed;
		s.want.sample_out = smp[15:0];
		s.want.level_used = lvl[1:0];
		return s;
	endfunction

	function automatic item_t rand_word();
		item_t it;
		it = item_t'(31'($urandom));
		if ($urandom_range(0, 99) < 75) begin
			it.command = CMD_TICK;
		end else begin
			it.command = CMD_WRITE;
			// mostly in-range addresses, the rest may fall outside the level
			if ($urandom_range(0, 99) < 85)
				it.write_index = $urandom_range(0, lvl_size(it.write_level) - 1);
			case ($urandom_range(0, 9))
				0: it.write_value = 16'sh8000;
				1: it.write_value = 16'sh7fff;
				default: ;
			endcase
		end
		return it;
	endfunction

	task automatic send_word(input item_t it, input bit typed, input result_t want);
		result_t calc;
		bit made;
		while (!steady && $urandom_range(0, 99) < 9) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		made = osc_advance(it, calc);
		if (made)
			due_samples.insert(due_samples.size(), typed ? want : calc);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		item_valid <= 1'b0;
		while (due_samples.size() != 0)
			@(negedge clk);
		// a write word may still be in flight after the last result
		repeat (SETTLE) @(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PHASE_INC: inc_reg = data;
			CFG_MORPH_POS: morph_reg = data[16:0];
			CFG_FRAME_CNT: fcnt_reg = data[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver side
	initial begin
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			result_ready <= steady || ($urandom_range(0, 99) >= 9);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (due_samples.size() == 0) begin
				$error("result word with nothing expected: sample_out %0d level_used %0d",
				       result.sample_out, result.level_used);
				err_cnt++;
			end else begin
				head = due_samples.pop_front();
				if (result.sample_out !== head.sample_out) begin
					$error("sample_out: expected %0d, got %0d", head.sample_out,
					       result.sample_out);
					err_cnt++;
				end
				if (result.level_used !== head.level_used) begin
					$error("level_used: expected %0d, got %0d", head.level_used,
					       result.level_used);
					err_cnt++;
				end
			end
		end
	end

	initial begin : stim
		step_t   plan [$];
		item_t   tick_w, tick_ones;
		int      n, ph, sent;
		int      v;
		int      nfr_pick;
		logic [CFG_DATA_W-1:0] inc_pick, morph_pick, fc_pick;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// level 0 frame 0 and level 3 frames 0 and 1; ticks are kept to these
		for (int k = 0; k < 384; k++) begin
			case ($urandom_range(0, 15))
				0: v = -32768;
				1: v = 32767;
				default: v = int'($signed(16'($urandom)));
			endcase
			if (k < 256)
				send_word(mk_word(CMD_WRITE, 0, 0, k, v), 1'b0, '0);
			else
				send_word(mk_word(CMD_WRITE, 3, (k - 256) / 64, (k - 256) % 64, v),
				          1'b0, '0);
		end

		tick_w = mk_word(CMD_TICK, 0, 0, 0, 0);
		tick_ones = mk_word(CMD_TICK, 3, 15, 255, -1);

		// silent table: level choice around the one-half boundary
		plan = {plan, at_word(tick_w, 1'b1, 0, 0)};
		plan = {plan, at_cfg(CFG_PHASE_INC, 32'h0100_0000)};
		plan = {plan, at_word(tick_w, 1'b1, 0, 0)};
		plan = {plan, at_cfg(CFG_PHASE_INC, 32'h0100_0001)};
		plan = {plan, at_word(tick_w, 1'b1, 0, 1)};
		plan = {plan, at_cfg(CFG_PHASE_INC, 32'h0200_0001)};
		plan = {plan, at_word(tick_w, 1'b1, 0, 2)};
		plan = {plan, at_cfg(CFG_PHASE_INC, 32'hffff_ffff)};
		plan = {plan, at_word(tick_ones, 1'b1, 0, 3)};
		// extreme samples, and writes beyond a level's size that must be dropped
		plan = {plan, at_word(mk_word(CMD_WRITE, 0, 0, 0, -32768), 1'b0, 0, 0)};
		plan = {plan, at_word(mk_word(CMD_WRITE, 0, 0, 1, 32767), 1'b0, 0, 0)};
		plan = {plan, at_word(mk_word(CMD_WRITE, 1, 3, 200, 1234), 1'b0, 0, 0)};
		plan = {plan, at_word(mk_word(CMD_WRITE, 2, 5, 64, -1), 1'b0, 0, 0)};
		plan = {plan, at_word(mk_word(CMD_WRITE, 3, 15, 255, 32767), 1'b0, 0, 0)};
		plan = {plan, at_word(mk_word(CMD_WRITE, 3, 15, 63, -32768), 1'b0, 0, 0)};
		// one frame, phase zero: reads the first entry as is
		plan = {plan, at_cfg(CFG_PHASE_INC, 32'h0000_0000)};
		plan = {plan, at_cfg(CFG_FRAME_CNT, 32'd1)};
		plan = {plan, at_cfg(CFG_MORPH_POS, 32'd0)};
		plan = {plan, at_word(tick_w, 1'b1, -32768, 0)};
		plan = {plan, at_cfg(CFG_PHASE_INC, 32'h00ff_ffff)};
		for (int k = 0; k < 3; k++)
			plan = {plan, at_word(tick_w, 1'b0, 0, 0)};
		// oversized frame count, morph kept low enough to stay in two frames
		plan = {plan, at_cfg(CFG_FRAME_CNT, 32'd31)};
		plan = {plan, at_cfg(CFG_MORPH_POS, 32'd4000)};
		plan = {plan, at_cfg(CFG_PHASE_INC, 32'hffff_ffff)};
		for (int k = 0; k < 2; k++)
			plan = {plan, at_word(tick_ones, 1'b0, 0, 0)};
		// oversized morph position over two frames
		plan = {plan, at_cfg(CFG_FRAME_CNT, 32'd2)};
		plan = {plan, at_cfg(CFG_MORPH_POS, 32'h1_ffff)};
		for (int k = 0; k < 2; k++)
			plan = {plan, at_word(tick_ones, 1'b0, 0, 0)};
		plan = {plan, at_cfg(CFG_MORPH_POS, 32'd32768)};
		plan = {plan, at_cfg(CFG_PHASE_INC, 32'h1000_0000)};
		for (int k = 0; k < 3; k++)
			plan = {plan, at_word(tick_w, 1'b0, 0, 0)};
		plan = {plan, at_cfg(CFG_MORPH_POS, 32'd65536)};
		for (int k = 0; k < 2; k++)
			plan = {plan, at_word(tick_w, 1'b0, 0, 0)};

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CFG)
				cfg_write(plan[i].idx, plan[i].data);
			else
				send_word(plan[i].word, plan[i].typed, plan[i].want);
		end

		ph = 0;
		sent = 0;
		while (sent < RAND_WORDS) begin
			steady = 1'b0;
			case ($urandom_range(0, 5))
				0: morph_pick = 32'd0;
				1: morph_pick = 32'd65536;
				2: morph_pick = 32'h1_ffff;
				default: morph_pick = $urandom_range(0, 32'h1_ffff);
			endcase
			case ($urandom_range(0, 9))
				0: fc_pick = 32'd0;
				1: fc_pick = 32'd1;
				2: fc_pick = 32'd16;
				3: fc_pick = 32'd31;
				default: fc_pick = $urandom_range(1, 16);
			endcase
			if (ph == 2 && fc_pick == 0)
				fc_pick = 32'd16;
			nfr_pick = (fc_pick > 32'd16) ? 16 : int'(fc_pick);
			if (nfr_pick == 0) begin
				case ($urandom_range(0, 5))
					0: inc_pick = '0;
					1: inc_pick = 32'hffff_ffff;
					2: inc_pick = 32'h0100_0000 << $urandom_range(0, 3);
					default: inc_pick = $urandom >> $urandom_range(0, 12);
				endcase
			end else if (nfr_pick == 1 && $urandom_range(0, 1) == 0) begin
				// level 0, single frame
				case ($urandom_range(0, 3))
					0: inc_pick = '0;
					1: inc_pick = 32'h0100_0000;
					default: inc_pick = $urandom >> $urandom_range(8, 16);
				endcase
			end else begin
				// level 3, reads stay within the first two frames
				case ($urandom_range(0, 3))
					0: inc_pick = 32'hffff_ffff;
					1: inc_pick = 32'h0400_0001;
					default: inc_pick = 32'h0400_0001 + ($urandom >> 1);
				endcase
				if (nfr_pick > 2)
					morph_pick = $urandom_range(0, 65535 / (nfr_pick - 1));
			end
			cfg_write(CFG_PHASE_INC, inc_pick);
			cfg_write(CFG_MORPH_POS, morph_pick);
			cfg_write(CFG_FRAME_CNT, fc_pick);
			if (ph == 2)
				hold_go = 1'b1;
			steady = (ph == 4);
			n = steady ? 90 : $urandom_range(20, 60);
			repeat (n) begin
				send_word(rand_word(), 1'b0, '0);
				sent++;
			end
			ph++;
		end
		steady = 1'b0;
		item_valid <= 1'b0;

		while (due_samples.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
